// File: hdl/lzss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared constants, token phase codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int MIN_MATCH = 3;
  localparam int CNT_W     = 5;   // holds 15 + MIN_MATCH

  localparam logic [31:0] SHORT_LIMIT  = 32'd16;
  localparam logic [3:0]  GROUP_TOKENS = 4'd8;

  // Position in the compressed stream
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_HDR2    = 3'd2,
    PH_HDR3    = 3'd3,
    PH_CONTROL = 3'd4,
    PH_TOKEN   = 3'd5,
    PH_REF2    = 3'd6
  } phase_t;

  // Controller states
  typedef enum logic [2:0] {
    S_RECV   = 3'b001,
    S_CPY_RD = 3'b010,
    S_CPY_WR = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic copy_rd;  // issue window read for the next copied byte
    logic copy_wr;  // retire the copied byte (emit and write back)
  } ctrl_cmd_t;

  typedef struct packed {
    logic ref_phase;   // next accepted byte closes a reference
    logic copy_emits;  // a copied byte would reach the output
    logic copy_last;   // current copied byte is the final one
    logic out_busy;    // output register holds a byte
  } dp_stat_t;

endpackage

// File: hdl/lzss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/lzss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS decompressor controller
// Sequences input transfers and the read/write steps of a reference copy.
// ----------------------------------------------------------------------------
module lzss_ctrl import lzss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      out_tready,
  input  dp_stat_t  st,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_free;
  logic        advance;

  assign out_free  = !st.out_busy || out_tready;
  assign in_tready = (state_r == S_RECV) && out_free;
  // a copied byte that is dropped needs no output slot
  assign advance   = !st.copy_emits || out_free;

  assign cmd.accept  = in_tready && in_tvalid;
  assign cmd.copy_rd = (state_r == S_CPY_RD);
  assign cmd.copy_wr = (state_r == S_CPY_WR) && advance;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_RECV: begin
        if (cmd.accept && st.ref_phase) begin
          state_nxt = S_CPY_RD;
        end
      end
      S_CPY_RD: begin
        state_nxt = S_CPY_WR;
      end
      S_CPY_WR: begin
        if (advance) begin
          state_nxt = st.copy_last ? S_RECV : S_CPY_RD;
        end
      end
      default: begin
        state_nxt = S_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/lzss_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS decompressor datapath
// Header and token decode, history window, output length tracking and the
// output register.
// ----------------------------------------------------------------------------
module lzss_dp import lzss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  ctrl_cmd_t  cmd,
  output dp_stat_t   st,
  input  logic       out_tready,
  output logic       out_tvalid,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  phase_t             phase_r, phase_nxt;
  logic [31:0]        total_r, total_nxt;
  logic [31:0]        produced_r, produced_nxt;
  logic [7:0]         flags_r, flags_nxt;
  logic [3:0]         tokens_r, tokens_nxt;
  logic [7:0]         pending_r, pending_nxt;
  logic [WIN_AW-1:0]  wpos_r, wpos_nxt;
  logic               finished_r, finished_nxt;
  logic [WIN_AW-1:0]  offset_r, offset_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               last_pend_r, last_pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;

  logic               can_emit;
  logic               emit_lit;
  logic               emit_go;
  logic               copy_zero;
  logic [7:0]         copy_byte;
  logic [7:0]         emit_data;
  logic [31:0]        prod_inc;
  logic [3:0]         tok_dec;
  phase_t             ph_after;
  logic [7:0]         ram_q;
  logic [WIN_AW-1:0]  rd_addr;

  assign can_emit  = !finished_r && (produced_r < total_r);
  assign emit_lit  = cmd.accept && (phase_r == PH_TOKEN) && !flags_r[0];
  assign emit_go   = (emit_lit || cmd.copy_wr) && can_emit;
  // offset zero or a reach past everything written so far reads as zero
  assign copy_zero = (offset_r == '0) || ({{(32-WIN_AW){1'b0}}, offset_r} > produced_r);
  assign copy_byte = copy_zero ? 8'd0 : ram_q;
  assign emit_data = cmd.copy_wr ? copy_byte : in_tdata;
  assign prod_inc  = produced_r + 32'd1;
  assign tok_dec   = (tokens_r != 4'd0) ? tokens_r - 4'd1 : 4'd0;
  assign ph_after  = (tok_dec == 4'd0) ? PH_CONTROL : PH_TOKEN;
  assign rd_addr   = wpos_r - offset_r;

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (WIN_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (emit_go),
    .waddr (wpos_r),
    .wdata (emit_data),
    .re    (cmd.copy_rd),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_comb begin
    phase_nxt     = phase_r;
    total_nxt     = total_r;
    produced_nxt  = produced_r;
    flags_nxt     = flags_r;
    tokens_nxt    = tokens_r;
    pending_nxt   = pending_r;
    wpos_nxt      = wpos_r;
    finished_nxt  = finished_r;
    offset_nxt    = offset_r;
    count_nxt     = count_r;
    last_pend_nxt = last_pend_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (cmd.accept && !finished_r) begin
      case (phase_r)
        PH_HDR0: begin
          total_nxt[7:0] = in_tdata;
          phase_nxt      = PH_HDR1;
        end
        PH_HDR1: begin
          total_nxt[15:8] = in_tdata;
          phase_nxt       = PH_HDR2;
        end
        PH_HDR2: begin
          total_nxt[23:16] = in_tdata;
          phase_nxt        = PH_HDR3;
        end
        PH_HDR3: begin
          total_nxt[31:24] = in_tdata;
          phase_nxt        = PH_CONTROL;
          if ({in_tdata, total_r[23:0]} <= SHORT_LIMIT) begin
            finished_nxt = 1'b1;
          end
        end
        PH_CONTROL: begin
          flags_nxt  = in_tdata;
          tokens_nxt = GROUP_TOKENS;
          phase_nxt  = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (!flags_r[0]) begin
            flags_nxt  = {1'b0, flags_r[7:1]};
            tokens_nxt = tok_dec;
            phase_nxt  = ph_after;
          end else begin
            pending_nxt = in_tdata;
            phase_nxt   = PH_REF2;
          end
        end
        PH_REF2: begin
          offset_nxt    = {in_tdata[3:0], pending_r};
          count_nxt     = {1'b0, in_tdata[7:4]} + CNT_W'(MIN_MATCH);
          last_pend_nxt = in_tlast;
          flags_nxt     = {1'b0, flags_r[7:1]};
          tokens_nxt    = tok_dec;
          phase_nxt     = ph_after;
        end
        default: begin
          finished_nxt = 1'b1;
        end
      endcase
      // a final byte that closes a reference takes effect after the copy
      if (in_tlast && (phase_r != PH_REF2)) begin
        finished_nxt = 1'b1;
      end
    end

    if (cmd.copy_wr) begin
      count_nxt = count_r - CNT_W'(1);
      if ((count_r == CNT_W'(1)) && last_pend_r) begin
        finished_nxt = 1'b1;
      end
    end

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_go) begin
      wpos_nxt      = wpos_r + WIN_AW'(1);
      produced_nxt  = prod_inc;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_data;
      out_last_nxt  = (prod_inc == total_r);
      if (prod_inc == total_r) begin
        finished_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      total_r     <= '0;
      produced_r  <= '0;
      flags_r     <= '0;
      tokens_r    <= '0;
      wpos_r      <= '0;
      finished_r  <= 1'b0;
      last_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      total_r     <= total_nxt;
      produced_r  <= produced_nxt;
      flags_r     <= flags_nxt;
      tokens_r    <= tokens_nxt;
      wpos_r      <= wpos_nxt;
      finished_r  <= finished_nxt;
      last_pend_r <= last_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pending_r  <= pending_nxt;
    offset_r   <= offset_nxt;
    count_r    <= count_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign st.ref_phase  = (phase_r == PH_REF2) && !finished_r;
  assign st.copy_emits = can_emit;
  assign st.copy_last  = (count_r == CNT_W'(1));
  assign st.out_busy   = out_valid_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

// File: hdl/lzss_stream_decompressor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS stream decompressor core
// Decodes an LZSS byte stream (4-byte length header, control bytes, literal
// and 12-bit offset / 4-bit length references) over a 4096-byte window.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                          Payload
//  --------  -----------------------------  ------------------------------
//  in        in_tvalid/in_tready/in_tlast   in_tdata[7:0] = in_byte
//  out       out_tvalid/out_tready/out_tlast out_tdata[7:0] = out_byte
//
//  Header, control and literal bytes are each taken in a single input
//  transfer. After a reference's second byte, each copied byte passes a
//  window read state, then an emit and write-back state. The registered
//  read of the single window RAM is why these are separate states.
//  Reset clears control state; the window needs no clearing pass, since a
//  reach beyond the bytes produced so far reads as zero.
//  A stalled output holds the output register and blocks the next input
//  transfer and any copy emit; bytes past the total length are dropped.
//
module lzss_stream_decompressor_core import lzss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast
);

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  // sequence transfers and copy steps
  lzss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  // decode, window and output register
  lzss_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .st         (st),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hdl/lzss_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS decompressor port checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module lzss_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // nothing follows the final byte
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("output after final byte");

  // input is taken only when the output register can take a byte
  a_in_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || out_tready)
    else $error("input ready while output stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind lzss_stream_decompressor_core lzss_chk u_lzss_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
